// ===== rtl/raa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raa_pkg: shared types and codes for the rational accumulator
// Mode codes, status codes and the divider command and response structs.
// ----------------------------------------------------------------------------
package raa_pkg;

	localparam logic [2:0] MODE_LOAD = 3'd0;
	localparam logic [2:0] MODE_ADD  = 3'd1;
	localparam logic [2:0] MODE_SUB  = 3'd2;
	localparam logic [2:0] MODE_MUL  = 3'd3;
	localparam logic [2:0] MODE_DIV  = 3'd4;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_ZERO = 2'd1;
	localparam logic [1:0] STAT_OVF  = 2'd2;

	// unsigned 64-bit divider handshake
	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [63:0] divisor;
	} div_cmd_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quot;
		logic [63:0] rem;
	} div_rsp_t;

endpackage

// ===== rtl/rational_accumulator_alu_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_accumulator_alu_core: rational accumulator with gcd reduction
// Sequencer, cross-product multiplier and shared divider for Euclid's gcd.
// ----------------------------------------------------------------------------
// Use: present mode/operand_num/operand_den with in_valid; the transaction is
// accepted when in_stall is low. One result transaction follows on
// out_valid with result_num, result_den and status; it is held while
// out_stall is high. The block accepts a new input only when idle and the
// result register is empty.
// Sequencing: products step through M1..M4 on one 33x33 signed multiplier.
// The gcd runs Euclid on the shared divider: one divide per remainder
// step (up to ~90 steps worst case, typically a handful), then two more
// divides by the gcd. Unused modes and zero operands skip both and go
// straight to the finish state.
// Reset: accumulator becomes 0/1, no result is pending.
// Stall: results wait in the output register; no new input is taken.
// ----------------------------------------------------------------------------
module rational_accumulator_alu_core
	import raa_pkg::*;
#(
	parameter int VALUE_BITS = 32
)(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         mode,
	input  logic signed [31:0] operand_num,
	input  logic signed [31:0] operand_den,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_num,
	output logic [30:0]        result_den,
	output logic [1:0]         status
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_M1   = 4'd1;
	localparam logic [3:0] S_M2   = 4'd2;
	localparam logic [3:0] S_M3   = 4'd3;
	localparam logic [3:0] S_M4   = 4'd4;
	localparam logic [3:0] S_SIGN = 4'd5;
	localparam logic [3:0] S_GCD  = 4'd6;
	localparam logic [3:0] S_GW   = 4'd7;
	localparam logic [3:0] S_DN   = 4'd8;
	localparam logic [3:0] S_DNW  = 4'd9;
	localparam logic [3:0] S_DDW  = 4'd10;
	localparam logic [3:0] S_FIN  = 4'd11;

	localparam logic signed [65:0] LIM = 66'sd1 <<< (VALUE_BITS - 1);

	logic [3:0]         state_q;
	logic [2:0]         mode_q;
	logic signed [32:0] on_q, od_q;
	logic signed [32:0] an_q, ad_q;
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod_q;
	logic signed [65:0] p1_q, rn_q, rd_q;
	logic [63:0]        ga_q, gb_q, mn_q;
	logic               neg_q;
	logic               ovalid_q;
	logic signed [31:0] rnum_q;
	logic [30:0]        rden_q;
	logic [1:0]         stat_q;
	div_cmd_t           dcmd;
	div_rsp_t           drsp;
	logic signed [65:0] qn_s, qd_s;

	raa_div u_div (.clk(clk), .arst_n(arst_n), .cmd(dcmd), .rsp(drsp));

	assign in_stall   = (state_q != S_IDLE) || ovalid_q;
	assign out_valid  = ovalid_q;
	assign result_num = rnum_q;
	assign result_den = rden_q;
	assign status     = stat_q;

	// multiplier operand select per product step
	always_comb begin
		ma = an_q;
		mb = od_q;
		unique case (state_q)
			S_M1: begin
				ma = an_q;
				mb = (mode_q == MODE_MUL) ? on_q : od_q;
			end
			S_M2: begin
				ma = ad_q;
				mb = (mode_q == MODE_DIV) ? on_q : od_q;
			end
			S_M3: begin
				ma = on_q;
				mb = ad_q;
			end
			default: begin
				ma = an_q;
				mb = od_q;
			end
		endcase
	end

	// divider command
	always_comb begin
		dcmd.start    = 1'b0;
		dcmd.dividend = ga_q;
		dcmd.divisor  = gb_q;
		unique case (state_q)
			S_GCD: dcmd.start = (gb_q != 64'd0);
			S_DN: begin
				dcmd.start    = 1'b1;
				dcmd.dividend = mn_q;
				dcmd.divisor  = ga_q;
			end
			S_DNW: begin
				dcmd.start    = drsp.done;
				dcmd.dividend = rd_q[63:0];
				dcmd.divisor  = ga_q;
			end
			default: dcmd.start = 1'b0;
		endcase
	end

	assign qn_s = neg_q ? -$signed({2'b00, mn_q}) : $signed({2'b00, mn_q});
	assign qd_s = $signed({2'b00, drsp.quot});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
			an_q     <= 33'sd0;
			ad_q     <= 33'sd1;
			rnum_q   <= '0;
			rden_q   <= 31'd1;
			stat_q   <= STAT_OK;
		end else begin
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && !in_stall) begin
					mode_q <= mode;
					if (operand_den[31] == 1'b1) begin
						on_q <= -$signed({operand_num[31], operand_num});
						od_q <= -$signed({operand_den[31], operand_den});
					end else begin
						on_q <= $signed({operand_num[31], operand_num});
						od_q <= $signed({operand_den[31], operand_den});
					end
					if (mode > MODE_DIV) begin
						stat_q <= STAT_OK;
						state_q <= S_FIN;
					end else if (operand_den == 32'sd0 ||
							(mode == MODE_DIV && operand_num == 32'sd0)) begin
						stat_q <= STAT_ZERO;
						state_q <= S_FIN;
					end else begin
						stat_q <= STAT_OK;
						state_q <= S_M1;
					end
				end
				S_M1: begin
					prod_q  <= ma * mb;
					state_q <= S_M2;
				end
				S_M2: begin
					p1_q    <= prod_q;
					prod_q  <= ma * mb;
					state_q <= S_M3;
				end
				S_M3: begin
					rd_q    <= prod_q;
					prod_q  <= ma * mb;
					state_q <= S_M4;
				end
				S_M4: begin
					unique case (mode_q)
						MODE_LOAD: begin
							rn_q <= 66'(on_q);
							rd_q <= 66'(od_q);
						end
						MODE_ADD: rn_q <= p1_q + prod_q;
						MODE_SUB: rn_q <= p1_q - prod_q;
						default:  rn_q <= p1_q;
					endcase
					state_q <= S_SIGN;
				end
				S_SIGN: begin
					// move sign to numerator, seed Euclid with magnitudes
					if (rd_q < 0) begin
						rd_q  <= -rd_q;
						neg_q <= (rn_q > 0);
						mn_q  <= (rn_q < 0) ? -rn_q[63:0] : rn_q[63:0];
						ga_q  <= (rn_q < 0) ? -rn_q[63:0] : rn_q[63:0];
						gb_q  <= -rd_q[63:0];
					end else begin
						neg_q <= (rn_q < 0);
						mn_q  <= (rn_q < 0) ? -rn_q[63:0] : rn_q[63:0];
						ga_q  <= (rn_q < 0) ? -rn_q[63:0] : rn_q[63:0];
						gb_q  <= rd_q[63:0];
					end
					if (rn_q == 0) begin
						rn_q    <= '0;
						rd_q    <= 66'sd1;
						state_q <= S_FIN;
						stat_q  <= STAT_OK;
						an_q    <= '0;
						ad_q    <= 33'sd1;
					end else begin
						state_q <= S_GCD;
					end
				end
				S_GCD: state_q <= (gb_q == 64'd0) ? S_DN : S_GW;
				S_GW: if (drsp.done) begin
					ga_q    <= gb_q;
					gb_q    <= drsp.rem;
					state_q <= S_GCD;
				end
				S_DN: state_q <= S_DNW;
				S_DNW: if (drsp.done) begin
					mn_q    <= drsp.quot;
					state_q <= S_DDW;
				end
				S_DDW: if (drsp.done) begin
					if (qn_s < -LIM || qn_s > LIM - 1 || qd_s > LIM - 1) begin
						stat_q <= STAT_OVF;
					end else begin
						an_q <= qn_s[32:0];
						ad_q <= qd_s[32:0];
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					rnum_q   <= an_q[31:0];
					rden_q   <= ad_q[30:0];
					ovalid_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (result_den != 31'd0))
		else $error("zero denominator reported");
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == S_FIN))
		else $error("result without finish");
	a_zero_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STAT_OK) |-> $stable(an_q))
		else $error("accumulator changed on error");
`endif

endmodule

// ===== rtl/raa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raa_div: shared restoring divider
// Unsigned 64 by 64 divide, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module raa_div
	import raa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_cmd_t cmd,
	output div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] quo_q;
	logic [63:0] rem_q;
	logic [63:0] dvs_q;
	logic [64:0] trial;
	logic [64:0] diff;

	// one shift-subtract step
	assign trial = {rem_q, quo_q[63]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quo_q <= cmd.dividend;
			rem_q <= '0;
			dvs_q <= cmd.divisor;
		end else if (busy_q) begin
			if (!diff[64]) begin
				rem_q <= diff[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule
